// File: hw/rtl/psfd_pkg.sv
// Package for the pressure sensor frame decoder: widths, codes, word and job types,
// and the CRC-8 and saturation helper functions.
// No dependencies.
`default_nettype none

package psfd_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_W    = 16;
	localparam int OUT_W     = 24;
	localparam int NUM_W     = WORD_W + FRAC_BITS;
	localparam int RES_W     = NUM_W + 1;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int SAT_W     = 40;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	localparam logic [7:0]        CRC_POLY     = 8'h31;
	localparam logic [WORD_W-1:0] TEMP_DIVISOR = 16'd200;

	// temperature divide by reciprocal; the extra 8 bits keep the reciprocal error
	// below one quotient step for every 16-bit magnitude
	localparam int TEMP_SHIFT   = WORD_W + FRAC_BITS + 8;
	localparam int TEMP_RECIP_W = TEMP_SHIFT - 7;
	localparam int TMUL_W       = WORD_W + TEMP_RECIP_W;
	localparam int TEMP_QLSB    = TEMP_SHIFT - FRAC_BITS;
	localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = TEMP_RECIP_W'(
		((64'd1 << TEMP_SHIFT) + 64'(TEMP_DIVISOR) - 64'd1) / 64'(TEMP_DIVISOR));

	localparam logic [3:0] FRAME_LEN_SINGLE = 4'd3;
	localparam logic [3:0] FRAME_LEN_CONT   = 4'd9;
	localparam logic [1:0] POS_CRC          = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_P_CRC    = 3'd1;
	localparam logic [2:0] STAT_T_CRC    = 3'd2;
	localparam logic [2:0] STAT_S_CRC    = 3'd3;
	localparam logic [2:0] STAT_NO_SCALE = 3'd4;

	localparam logic [1:0] CFG_SINGLE_SHOT = 2'd0;
	localparam logic [1:0] CFG_MANUAL_SCALE = 2'd1;
	localparam logic [1:0] CFG_PRESSURE_RAW = 2'd2;
	localparam logic [1:0] CFG_TEMP_RAW     = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pressure_value;
		logic signed [OUT_W-1:0] temperature_value;
		logic                    temperature_valid;
		logic [WORD_W-1:0]       scale_used;
		logic [2:0]              status;
	} out_word_t;

	typedef struct packed {
		logic              single_shot_mode;
		logic [WORD_W-1:0] manual_scale;
		logic              pressure_raw_out;
		logic              temperature_raw_out;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        err;
		logic [WORD_W-1:0] pres_word;
		logic [WORD_W-1:0] temp_word;
		logic [WORD_W-1:0] scale;
		logic              single;
		logic              praw;
		logic              traw;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_FIN,
		BK_DONE
	} bk_state_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
		logic signed [SAT_W-1:0] vx;
		vx = SAT_W'(v);
		if (vx > SAT_W'(8388607)) begin
			return 24'sh7FFFFF;
		end else if (vx < -SAT_W'(8388608)) begin
			return 24'sh800000;
		end
		return vx[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/psfd_front.sv
// Front end: configuration registers, byte intake, CRC check and frame assembly.
// Pushes one job per completed frame into the job queue. Uses psfd_pkg.
`default_nettype none

module psfd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire psfd_pkg::in_word_t in_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output psfd_pkg::job_t        q_job
);
	import psfd_pkg::*;

	cfg_t              cfg_q;
	logic [3:0]        byte_index_q;
	logic [7:0]        crc_q;
	logic [2:0]        ferr_q;
	logic [WORD_W-1:0] pres_q;
	logic [WORD_W-1:0] temp_q;
	logic [WORD_W-1:0] scale_q;
	logic [WORD_W-1:0] last_scale_q;

	logic              accept;
	logic [3:0]        len;
	logic [3:0]        idx;
	logic [3:0]        idx_inc;
	logic [7:0]        crc_cur;
	logic [2:0]        ferr_cur;
	logic [2:0]        ferr_next;
	logic [1:0]        grp;
	logic [1:0]        pos;
	logic              active;
	logic              frame_end;
	logic              take_scale;
	logic [WORD_W-1:0] last_next;
	logic [WORD_W-1:0] eff;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		len      = cfg_q.single_shot_mode ? FRAME_LEN_SINGLE : FRAME_LEN_CONT;
		idx      = in_data.frame_start ? 4'd0 : byte_index_q;
		crc_cur  = in_data.frame_start ? 8'd0 : crc_q;
		ferr_cur = in_data.frame_start ? STAT_OK : ferr_q;
		idx_inc  = idx + 4'd1;
		active   = idx < len;
		case (idx) inside
			4'd0, 4'd1, 4'd2: grp = 2'd0;
			4'd3, 4'd4, 4'd5: grp = 2'd1;
			4'd6, 4'd7, 4'd8: grp = 2'd2;
			default:          grp = 2'd0;
		endcase
		case (idx) inside
			4'd0, 4'd3, 4'd6: pos = 2'd0;
			4'd1, 4'd4, 4'd7: pos = 2'd1;
			4'd2, 4'd5, 4'd8: pos = POS_CRC;
			default:          pos = 2'd0;
		endcase
		ferr_next = ferr_cur;
		if (pos == POS_CRC && crc_cur != in_data.rx_byte && ferr_cur == STAT_OK) begin
			ferr_next = 3'(grp) + 3'd1;
		end
		frame_end  = accept && active && idx_inc == len;
		take_scale = ferr_next == STAT_OK && !cfg_q.single_shot_mode && scale_q != '0;
		last_next  = take_scale ? scale_q : last_scale_q;
		eff        = cfg_q.manual_scale != '0 ? cfg_q.manual_scale : last_next;

		q_push          = frame_end;
		q_job.pres_word = pres_q;
		q_job.temp_word = temp_q;
		q_job.scale     = eff;
		q_job.single    = cfg_q.single_shot_mode;
		q_job.praw      = cfg_q.pressure_raw_out;
		q_job.traw      = cfg_q.temperature_raw_out;
		if (ferr_next != STAT_OK) begin
			q_job.err = ferr_next;
		end else if (eff == '0) begin
			q_job.err = STAT_NO_SCALE;
		end else begin
			q_job.err = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SINGLE_SHOT:  cfg_q.single_shot_mode    <= cfg_data[0];
				CFG_MANUAL_SCALE: cfg_q.manual_scale        <= cfg_data;
				CFG_PRESSURE_RAW: cfg_q.pressure_raw_out    <= cfg_data[0];
				CFG_TEMP_RAW:     cfg_q.temperature_raw_out <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q        <= '0;
			ferr_q       <= STAT_OK;
			pres_q       <= '0;
			temp_q       <= '0;
			scale_q      <= '0;
			last_scale_q <= '0;
		end else if (accept) begin
			if (active) begin
				byte_index_q <= idx_inc;
				ferr_q       <= ferr_next;
				if (pos == POS_CRC) begin
					crc_q <= '0;
				end else begin
					crc_q <= crc_byte(crc_cur ^ in_data.rx_byte);
					unique case (grp)
						2'd0: begin
							if (pos == 2'd0) pres_q[15:8] <= in_data.rx_byte;
							else pres_q[7:0] <= in_data.rx_byte;
						end
						2'd1: begin
							if (pos == 2'd0) temp_q[15:8] <= in_data.rx_byte;
							else temp_q[7:0] <= in_data.rx_byte;
						end
						default: begin
							if (pos == 2'd0) scale_q[15:8] <= in_data.rx_byte;
							else scale_q[7:0] <= in_data.rx_byte;
						end
					endcase
				end
				if (frame_end) begin
					last_scale_q <= last_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/psfd_queue.sv
// Four-entry job queue between the front end and the conversion back end.
// Uses psfd_pkg.
`default_nettype none

module psfd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire psfd_pkg::job_t push_job,
	input  wire logic           pop,
	output psfd_pkg::job_t      head_job,
	output logic                full,
	output logic                empty
);
	import psfd_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/psfd_back.sv
// Back end: takes jobs from the queue, divides pressure with a serial restoring divider,
// scales temperature by a reciprocal multiply, and holds the result word in an output
// register. Uses psfd_pkg.
`default_nettype none

module psfd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire psfd_pkg::job_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output psfd_pkg::out_word_t out_data
);
	import psfd_pkg::*;

	bk_state_t               state_q;
	bk_state_t               state_d;
	job_t                    job_q;
	logic                    phase_q;
	logic [NUM_W-1:0]        num_q;
	logic [WORD_W-1:0]       rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [OUT_W-1:0] res_p_q;
	logic signed [OUT_W-1:0] res_t_q;
	logic                    out_valid_q;
	out_word_t               out_q;

	logic                    deliver;
	logic                    last_phase;
	logic                    cur_raw;
	logic [WORD_W-1:0]       cur_word;
	logic [WORD_W-1:0]       cur_mag;
	logic [WORD_W-1:0]       divisor;
	logic signed [RES_W-1:0] raw_v;
	logic signed [RES_W-1:0] quo_v;
	logic [WORD_W:0]         rem_sh;
	logic [WORD_W:0]         rem_sub;
	logic                    ge;
	logic signed [OUT_W-1:0] load_v;
	logic [TMUL_W-1:0]       tmul;
	out_word_t               out_next;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		last_phase = phase_q || job_q.single;
		cur_raw    = phase_q ? job_q.traw : job_q.praw;
		cur_word   = phase_q ? job_q.temp_word : job_q.pres_word;
		cur_mag    = cur_word[WORD_W-1] ? WORD_W'(~cur_word + 16'd1) : cur_word;
		divisor    = job_q.scale;
		raw_v      = RES_W'($signed(cur_word)) <<< FRAC_BITS;
		quo_v      = cur_word[WORD_W-1] ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
		rem_sh     = {rem_q, num_q[NUM_W-1]};
		rem_sub    = rem_sh - {1'b0, divisor};
		ge         = rem_sh >= {1'b0, divisor};
		load_v     = (state_q == BK_FIN) ? sat_out(quo_v) : sat_out(raw_v);
		tmul       = TMUL_W'(cur_mag) * TMUL_W'(TEMP_RECIP);

		out_next        = '0;
		out_next.status = job_q.err;
		if (job_q.err == STAT_OK) begin
			out_next.pressure_value = res_p_q;
			out_next.scale_used     = job_q.scale;
			if (!job_q.single) begin
				out_next.temperature_value = res_t_q;
				out_next.temperature_valid = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		deliver = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				if (job_q.err != STAT_OK) begin
					state_d = BK_DONE;
				end else if (cur_raw) begin
					state_d = last_phase ? BK_DONE : BK_LOAD;
				end else if (phase_q) begin
					state_d = BK_FIN;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == CNT_LAST) state_d = BK_FIN;
			end
			BK_FIN: begin
				state_d = last_phase ? BK_DONE : BK_LOAD;
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					deliver = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q   <= q_head;
			phase_q <= 1'b0;
		end
		if (state_q == BK_LOAD && job_q.err == STAT_OK) begin
			if (cur_raw) begin
				if (phase_q) res_t_q <= load_v;
				else res_p_q <= load_v;
				phase_q <= 1'b1;
			end else if (phase_q) begin
				num_q <= NUM_W'(tmul[TMUL_W-1:TEMP_QLSB]);
			end else begin
				num_q <= NUM_W'(cur_mag) << FRAC_BITS;
				rem_q <= '0;
				cnt_q <= '0;
			end
		end
		if (state_q == BK_DIV) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == BK_FIN) begin
			if (phase_q) res_t_q <= load_v;
			else res_p_q <= load_v;
			phase_q <= 1'b1;
		end
		if (deliver) begin
			out_q <= out_next;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/pressure_sensor_frame_decoder_unit.sv
// After the last byte of a frame, the job passes through the job queue and the back end states
// IDLE, LOAD, DIV, FIN and DONE; frames with an error skip DIV and FIN, and frames with no
// pressure division skip DIV. Pressure divides one quotient bit per cycle, temperature by a
// reciprocal multiply. Queued frames and output stalls delay out_valid.
// Throughput: one byte per cycle while the four-entry job queue has room. Reset clears
// configuration, frame state and queue.
`default_nettype none

module pressure_sensor_frame_decoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire psfd_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output psfd_pkg::out_word_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import psfd_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	psfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (push),
		.q_job     (push_job)
	);

	psfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	psfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_job),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_OK |->
			out_data.pressure_value == '0 && out_data.scale_used == '0)
		else $error("error word carries nonzero payload");

	a_ok_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_OK |-> out_data.scale_used != '0)
		else $error("ok word with zero scale");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= STAT_NO_SCALE)
		else $error("status code out of range");

	a_temp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.temperature_valid |-> out_data.status == STAT_OK)
		else $error("temperature flagged valid on an error word");

endmodule

`default_nettype wire

// File: test/pressure_sensor_frame_decoder_unit_tb.sv
// Testbench for pressure_sensor_frame_decoder_unit: a directed table of sensor frames,
// then random frames under several register settings, checked word by word.
// Depends on psfd_pkg and the decoder RTL; needs no files or arguments.

module pressure_sensor_frame_decoder_unit_tb;
	import psfd_pkg::*;

	localparam int PHASE_BYTES = 155;
	localparam int NUM_PHASES  = 9;
	localparam int SETTLE_CYC  = 80;
	localparam int HOLD_CYC    = 1500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIR_ROWS    = 30;

	typedef enum logic [1:0] {
		ROW_DATA,
		ROW_CRC_OK,
		ROW_CRC_BAD
	} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic [7:0] data;
		logic       start;
		logic       has_res;
		out_word_t  res;
	} dir_row_t;

	localparam out_word_t OUT_NONE     = '0;
	localparam out_word_t ERR_NO_SCALE = '{24'sd0, 24'sd0, 1'b0, 16'd0, STAT_NO_SCALE};
	localparam out_word_t ERR_P_CRC    = '{24'sd0, 24'sd0, 1'b0, 16'd0, STAT_P_CRC};

	// CRC rows take their byte from the running CRC of the two data rows before them
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// no frame start after reset, zero scale everywhere
		'{ROW_DATA,    8'h7F, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'hFF, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h80, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b1, ERR_NO_SCALE},
		// extremes, scale one
		'{ROW_DATA,    8'h80, 1'b1, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h7F, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'hFF, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h01, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		// stray byte past frame end
		'{ROW_DATA,    8'hFF, 1'b0, 1'b0, OUT_NONE},
		// partial frame, then restart
		'{ROW_DATA,    8'h12, 1'b1, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h34, 1'b0, 1'b0, OUT_NONE},
		// pressure and scale CRC both bad: first one wins
		'{ROW_DATA,    8'hFF, 1'b1, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'hFF, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_BAD, 8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_OK,  8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'hFF, 1'b0, 1'b0, OUT_NONE},
		'{ROW_DATA,    8'h00, 1'b0, 1'b0, OUT_NONE},
		'{ROW_CRC_BAD, 8'h00, 1'b0, 1'b1, ERR_P_CRC}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_word_t    in_data   = '0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	// decoder copy: registers and frame state
	cfg_t        cfg_m        = '0;
	logic [3:0]  fr_index     = '0;
	logic [7:0]  fr_crc       = '0;
	logic [15:0] p_word       = '0;
	logic [15:0] t_word       = '0;
	logic [15:0] s_word       = '0;
	logic [2:0]  fr_err       = STAT_OK;
	logic [15:0] stored_scale = '0;

	out_word_t   decoded_due[$];
	out_word_t   due_word;
	int          bytes_taken = 0;
	int          fail_count  = 0;
	int          cycles      = 0;
	bit          hold_req    = 1'b0;
	bit          burst       = 1'b0;

	pressure_sensor_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] v_in);
		logic [7:0] v;
		v = v_in;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	function automatic logic signed [23:0] clamp24(input longint v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	task automatic decode_byte(input in_word_t w, output bit done, output out_word_t res);
		logic [3:0]  len;
		logic [3:0]  grp;
		logic [3:0]  pos;
		logic [15:0] eff;
		longint      pv;
		longint      tv;
		done = 1'b0;
		res = '0;
		len = cfg_m.single_shot_mode ? FRAME_LEN_SINGLE : FRAME_LEN_CONT;
		if (w.frame_start) begin
			fr_index = '0;
			fr_crc = '0;
			fr_err = STAT_OK;
		end
		if (fr_index >= len) begin
			return;
		end
		bytes_taken++;
		grp = 4'(fr_index / 3);
		pos = 4'(fr_index % 3);
		if (pos != 4'(POS_CRC)) begin
			fr_crc = crc8_step(fr_crc ^ w.rx_byte);
			if (grp == 0) begin
				if (pos == 0) p_word[15:8] = w.rx_byte; else p_word[7:0] = w.rx_byte;
			end else if (grp == 1) begin
				if (pos == 0) t_word[15:8] = w.rx_byte; else t_word[7:0] = w.rx_byte;
			end else begin
				if (pos == 0) s_word[15:8] = w.rx_byte; else s_word[7:0] = w.rx_byte;
			end
		end else begin
			if (fr_crc != w.rx_byte && fr_err == STAT_OK) begin
				fr_err = 3'(grp + 1);
			end
			fr_crc = '0;
		end
		fr_index = fr_index + 4'd1;
		if (fr_index != len) begin
			return;
		end
		done = 1'b1;
		if (fr_err != STAT_OK) begin
			res.status = fr_err;
			return;
		end
		if (!cfg_m.single_shot_mode && s_word != 0) begin
			stored_scale = s_word;
		end
		eff = (cfg_m.manual_scale != 0) ? cfg_m.manual_scale : stored_scale;
		if (eff == 0) begin
			res.status = STAT_NO_SCALE;
			return;
		end
		pv = longint'($signed(p_word)) * (longint'(1) << FRAC_BITS);
		res.pressure_value = clamp24(cfg_m.pressure_raw_out ? pv : pv / longint'(eff));
		if (!cfg_m.single_shot_mode) begin
			tv = longint'($signed(t_word)) * (longint'(1) << FRAC_BITS);
			res.temperature_value =
				clamp24(cfg_m.temperature_raw_out ? tv : tv / longint'(TEMP_DIVISOR));
			res.temperature_valid = 1'b1;
		end
		res.scale_used = eff;
		res.status = STAT_OK;
	endtask

	function automatic int pick_gap();
		int r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return $urandom_range(20, 120);
		end else if (r < 8) begin
			return $urandom_range(1, 3);
		end
		return 0;
	endfunction

	task automatic send_byte(input in_word_t w, input bit fixed, input out_word_t fixed_res);
		int        gap;
		bit        done;
		out_word_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(w, done, res);
		if (done) begin
			decoded_due.push_back(fixed ? fixed_res : res);
		end
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 9))
			0, 1: return 16'h0000;
			2: return 16'h0001;
			3: return 16'hFFFF;
			4, 5: return 16'($urandom_range(1, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_group(input logic [15:0] v, input bit with_start);
		logic [7:0] acc;
		logic [7:0] crc_b;
		acc = crc8_step(crc8_step(v[15:8]) ^ v[7:0]);
		crc_b = ($urandom_range(0, 9) == 0) ? (acc ^ 8'($urandom_range(1, 255))) : acc;
		send_byte('{v[15:8], with_start}, 1'b0, OUT_NONE);
		send_byte('{v[7:0], 1'b0}, 1'b0, OUT_NONE);
		send_byte('{crc_b, 1'b0}, 1'b0, OUT_NONE);
	endtask

	task automatic send_random_frame();
		int r;
		int len;
		int n;
		len = cfg_m.single_shot_mode ? 3 : 9;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			send_group(pick_word(), $urandom_range(0, 9) != 0);
			if (len == 9) begin
				send_group(pick_word(), 1'b0);
				send_group(pick_scale(), 1'b0);
			end
		end else if (r < 90) begin
			// truncated frame, abandoned by the next byte with frame_start set
			n = $urandom_range(1, len - 1);
			for (int i = 0; i < n; i++) begin
				send_byte('{8'($urandom), i == 0}, 1'b0, OUT_NONE);
			end
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				send_byte('{8'($urandom), $urandom_range(0, 2) == 0}, 1'b0, OUT_NONE);
			end
		end
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SINGLE_SHOT;
		cfg_data <= {15'($urandom), c.single_shot_mode};
		@(posedge clk);
		cfg_index <= CFG_MANUAL_SCALE;
		cfg_data <= c.manual_scale;
		@(posedge clk);
		cfg_index <= CFG_PRESSURE_RAW;
		cfg_data <= {15'($urandom), c.pressure_raw_out};
		@(posedge clk);
		cfg_index <= CFG_TEMP_RAW;
		cfg_data <= {15'($urandom), c.temperature_raw_out};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_m = c;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	initial begin
		dir_row_t   row;
		logic [7:0] acc;
		logic [7:0] b;
		cfg_t       c;
		int         base;
		acc = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			if (row.kind == ROW_DATA) begin
				if (row.start) acc = '0;
				b = row.data;
				acc = crc8_step(acc ^ b);
			end else begin
				b = (row.kind == ROW_CRC_OK) ? acc : (acc ^ 8'h5A);
				acc = '0;
			end
			send_byte('{b, row.start}, row.has_res, row.res);
		end
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: c = '{1'b0, 16'd0, 1'b0, 1'b0};
				1: c = '{1'b1, 16'd0, 1'b0, 1'b0};
				2: c = '{1'b0, 16'hFFFF, 1'b1, 1'b0};
				3: c = '{1'b1, 16'd1, 1'b0, 1'b1};
				4: c = '{1'b0, 16'($urandom_range(2, 300)), 1'b1, 1'b1};
				5: c = '{1'b0, 16'd0, 1'b0, 1'b1};
				6: c = '{1'b1, 16'hFFFF, 1'b1, 1'b0};
				7: c = '{1'b0, 16'd1, 1'b0, 1'b0};
				default: c = '{1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)};
			endcase
			burst = (p == 2);
			write_cfg(c);
			// long sink stall while words keep coming
			if (p == 2) hold_req = 1'b1;
			base = bytes_taken;
			while (bytes_taken - base < PHASE_BYTES) begin
				send_random_frame();
			end
			drain();
		end
		burst = 1'b0;

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int run;
		int gap;
		int r;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end
			run = $urandom_range(1, 40);
			out_ready <= 1'b1;
			for (int i = 0; i < run && !hold_req; i++) @(posedge clk);
			r = $urandom_range(0, 19);
			gap = (r == 0) ? $urandom_range(20, 150) : ((r < 10) ? $urandom_range(1, 4) : 0);
			if (gap > 0 && !hold_req) begin
				out_ready <= 1'b0;
				for (int i = 0; i < gap && !hold_req; i++) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (decoded_due.size() == 0) begin
				$error("result word with nothing pending: status %0d", out_data.status);
				fail_count++;
			end else begin
				due_word = decoded_due.pop_front();
				if (out_data.pressure_value !== due_word.pressure_value) begin
					$error("pressure_value: expected %0d, got %0d",
						due_word.pressure_value, out_data.pressure_value);
					fail_count++;
				end
				if (out_data.temperature_value !== due_word.temperature_value) begin
					$error("temperature_value: expected %0d, got %0d",
						due_word.temperature_value, out_data.temperature_value);
					fail_count++;
				end
				if (out_data.temperature_valid !== due_word.temperature_valid) begin
					$error("temperature_valid: expected %0d, got %0d",
						due_word.temperature_valid, out_data.temperature_valid);
					fail_count++;
				end
				if (out_data.scale_used !== due_word.scale_used) begin
					$error("scale_used: expected %0d, got %0d",
						due_word.scale_used, out_data.scale_used);
					fail_count++;
				end
				if (out_data.status !== due_word.status) begin
					$error("status: expected %0d, got %0d", due_word.status, out_data.status);
					fail_count++;
				end
			end
		end
	end

endmodule

// File: files.f
hw/rtl/psfd_pkg.sv
hw/rtl/psfd_front.sv
hw/rtl/psfd_queue.sv
hw/rtl/psfd_back.sv
hw/rtl/pressure_sensor_frame_decoder_unit.sv
test/pressure_sensor_frame_decoder_unit_tb.sv
